>>> rtl/sqtn_pkg.sv
// shared types and constants of the square tone and noise generator
package sqtn_pkg;

  // input item selector codes
  typedef enum logic [1:0] {
    FUNC_TONE  = 2'd0,
    FUNC_NOISE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // effect currently playing
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_TONE    = 2'd1,
    MODE_SILENCE = 2'd2,
    MODE_NOISE   = 2'd3
  } mode_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_CNT,
    ST_HP,
    ST_HP_WAIT,
    ST_COMMIT
  } state_e;

  // field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned FREQ_W   = 15;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned DIVS_W   = FREQ_W + 1;

  // sample levels and noise constants
  localparam logic [SAMPLE_W-1:0] LEVEL_HI   = 8'hC0;
  localparam logic [SAMPLE_W-1:0] LEVEL_LO   = 8'h40;
  localparam logic [SAMPLE_W-1:0] LEVEL_MID  = 8'h80;
  localparam logic [SAMPLE_W-1:0] NOISE_BASE = 8'h60;
  localparam logic [15:0]         NOISE_POLY = 16'hB400;
  localparam logic [15:0]         NOISE_SEED = 16'hACE1;
  localparam int unsigned         MS_PER_S   = 1000;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic cnt_sat_load;
    logic cnt_load;
    logic hp_load;
    logic commit;
    logic tick_step;
  } sqtn_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sat;
    logic need_hp;
    logic div_done;
    logic tick_live;
    logic out_free;
  } sqtn_sts_t;

endpackage

>>> rtl/square_tone_and_noise_generator_top.sv
// Square tone and noise sample generator, top level.
// A tick item passes through the tick state, where a live effect writes its sample into the output register;
// a tick waits while the output register holds an item that is not taken.
// A tone start passes through the count, half period, divider wait and commit states, for one pass of
// the one-bit-per-cycle half period divider; noise and silence starts skip the divider wait.
// An unused selector is accepted with no effect. Reset clears all effect state to idle, noise at its seed.
module square_tone_and_noise_generator_top #(
  parameter int unsigned MAX_COUNT = 4096,
  parameter int unsigned RATE_HZ   = 8000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sqtn_pkg::FUNC_W-1:0]       func_i,
  input  logic [sqtn_pkg::FREQ_W-1:0]       freq_hz_i,
  input  logic [sqtn_pkg::DUR_W-1:0]        duration_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sqtn_pkg::SAMPLE_W-1:0]     sample_o,
  output logic                              last_o
);

  import sqtn_pkg::*;

  sqtn_cmd_t cmd;
  sqtn_sts_t sts;

  // sequencing
  sqtn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  sqtn_dp #(
    .MAX_COUNT (MAX_COUNT),
    .RATE_HZ   (RATE_HZ)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .freq_hz_i     (freq_hz_i),
    .duration_ms_i (duration_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_o      (sample_o),
    .last_o        (last_o)
  );

endmodule

>>> rtl/sqtn_div.sv
// iterative restoring divider, one quotient bit per cycle
module sqtn_div #(
  parameter int unsigned DIVD_W = 23,
  parameter int unsigned DIVS_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DIVS_W:0]   rem_shift;
  logic [DIVS_W:0]   rem_diff;
  logic              fits;

  // one restoring step
  always_comb begin
    rem_shift = {rem_q, quo_q[DIVD_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs_q};
    fits      = (rem_shift >= {1'b0, dvs_q});
  end

  // iteration control
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = CNT_W'(DIVD_W);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[DIVD_W-2:0], fits};
      rem_d = fits ? rem_diff[DIVS_W-1:0] : rem_shift[DIVS_W-1:0];
      if (cnt_q == CNT_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/sqtn_dp.sv
// datapath: item capture, count and half period arithmetic, effect state, output register
module sqtn_dp #(
  parameter int unsigned MAX_COUNT = 4096,
  parameter int unsigned RATE_HZ   = 8000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sqtn_pkg::sqtn_cmd_t               cmd_i,
  output sqtn_pkg::sqtn_sts_t               sts_o,
  input  logic [sqtn_pkg::FUNC_W-1:0]       func_i,
  input  logic [sqtn_pkg::FREQ_W-1:0]       freq_hz_i,
  input  logic [sqtn_pkg::DUR_W-1:0]        duration_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sqtn_pkg::SAMPLE_W-1:0]     sample_o,
  output logic                              last_o
);

  import sqtn_pkg::*;

  localparam int unsigned RATE_W  = $clog2(RATE_HZ + 1);
  localparam int unsigned PROD_W  = DUR_W + RATE_W;
  localparam int unsigned SAT_VAL = MAX_COUNT * MS_PER_S;
  localparam int unsigned CNT_W   = $clog2(MAX_COUNT + 1);
  localparam int unsigned HP_W    = $clog2(RATE_HZ / 2 + 1);
  // reciprocal of 1000, exact for every product below the saturation point
  localparam int unsigned     X_W    = $clog2(SAT_VAL);
  localparam int unsigned     RCP_SH = X_W + 10;
  localparam int unsigned     MUL_W  = RCP_SH + CNT_W;
  localparam longint unsigned RCP    = ((64'd1 << RCP_SH) + MS_PER_S - 1) / MS_PER_S;

  // captured item
  logic [FUNC_W-1:0] func_q;
  logic [FREQ_W-1:0] freq_q;
  logic [PROD_W-1:0] prod_q;

  // computed effect parameters
  logic [CNT_W-1:0]  cnt_q;
  logic [HP_W-1:0]   hp_new_q;
  logic [MUL_W-1:0]  cnt_prod;

  // effect state
  mode_e             mode_q, mode_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [HP_W-1:0]   hp_q, hp_d;
  logic [HP_W-1:0]   phase_q, phase_d;
  logic              level_q, level_d;
  logic [15:0]       noise_q, noise_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic                last_q, last_d;

  // divider hookup
  logic [RATE_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [RATE_W-1:0] div_quo;

  // tick helpers
  logic [HP_W:0]      phase_inc;
  logic [15:0]        noise_next;
  logic [CNT_W-1:0]   left_dec;
  logic [SAMPLE_W-1:0] smp;

  // capture the item and scale the duration by the sample rate
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      freq_q <= freq_hz_i;
      prod_q <= PROD_W'(duration_ms_i) * PROD_W'(RATE_HZ);
    end
  end

  // sample count by reciprocal multiplication
  always_comb begin
    cnt_prod = MUL_W'(prod_q[X_W-1:0]) * MUL_W'(RCP);
  end

  // divider operands for the half period
  assign div_dividend = RATE_W'(RATE_HZ);
  assign div_divisor  = {freq_q, 1'b0};

  sqtn_div #(
    .DIVD_W (RATE_W),
    .DIVS_W (DIVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sample count and half period results
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_sat_load) begin
      cnt_q <= CNT_W'(MAX_COUNT);
    end else if (cmd_i.cnt_load) begin
      cnt_q <= cnt_prod[RCP_SH +: CNT_W];
    end
    if (cmd_i.hp_load) begin
      hp_new_q <= (div_quo == '0) ? HP_W'(1) : div_quo[HP_W-1:0];
    end
  end

  // per tick sample values
  always_comb begin
    phase_inc  = {1'b0, phase_q} + 1'b1;
    noise_next = (noise_q >> 1) ^ (noise_q[0] ? NOISE_POLY : 16'h0000);
    left_dec   = left_q - 1'b1;
    case (mode_q)
      MODE_TONE:  smp = level_q ? LEVEL_HI : LEVEL_LO;
      MODE_NOISE: smp = NOISE_BASE + {2'b00, noise_next[5:0]};
      default:    smp = LEVEL_MID;
    endcase
  end

  // effect state update
  always_comb begin
    mode_d      = mode_q;
    left_d      = left_q;
    hp_d        = hp_q;
    phase_d     = phase_q;
    level_d     = level_q;
    noise_d     = noise_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    last_d      = last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.commit) begin
      left_d = cnt_q;
      if (func_q == FUNC_TONE) begin
        phase_d = '0;
        level_d = 1'b1;
        if (freq_q == '0) begin
          mode_d = MODE_SILENCE;
        end else begin
          hp_d   = hp_new_q;
          mode_d = MODE_TONE;
        end
      end else begin
        mode_d = MODE_NOISE;
      end
      if (cnt_q == '0) begin
        mode_d = MODE_IDLE;
      end
    end else if (cmd_i.tick_step) begin
      case (mode_q)
        MODE_TONE: begin
          if (phase_inc >= {1'b0, hp_q}) begin
            phase_d = '0;
            level_d = ~level_q;
          end else begin
            phase_d = phase_inc[HP_W-1:0];
          end
        end
        MODE_NOISE: noise_d = noise_next;
        default: ;
      endcase
      left_d      = left_dec;
      out_valid_d = 1'b1;
      sample_d    = smp;
      last_d      = (left_dec == '0);
      if (left_dec == '0) begin
        mode_d = MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      left_q      <= '0;
      hp_q        <= HP_W'(1);
      phase_q     <= '0;
      level_q     <= 1'b1;
      noise_q     <= NOISE_SEED;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      left_q      <= left_d;
      hp_q        <= hp_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      noise_q     <= noise_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  // status to controller
  always_comb begin
    sts_o.sat       = (prod_q >= PROD_W'(SAT_VAL));
    sts_o.need_hp   = (func_q == FUNC_TONE) && (freq_q != '0);
    sts_o.div_done  = div_done;
    sts_o.tick_live = (mode_q != MODE_IDLE) && (left_q != '0);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

>>> rtl/sqtn_ctrl.sv
// controller: sequences item decode, divides, state commit and tick output
module sqtn_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sqtn_pkg::FUNC_W-1:0]  func_i,
  input  sqtn_pkg::sqtn_sts_t          sts_i,
  output sqtn_pkg::sqtn_cmd_t          cmd_o
);

  import sqtn_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_TICK) begin
            state_d = ST_TICK;
          end else if (func_i == FUNC_TONE || func_i == FUNC_NOISE) begin
            state_d = ST_CNT;
          end
        end
      end
      ST_TICK: begin
        if (!sts_i.tick_live || sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CNT:      state_d = ST_HP;
      ST_HP:       state_d = sts_i.need_hp ? ST_HP_WAIT : ST_COMMIT;
      ST_HP_WAIT:  if (sts_i.div_done) state_d = ST_COMMIT;
      ST_COMMIT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = accept;
      end
      ST_TICK: begin
        cmd_o.tick_step = sts_i.tick_live && sts_i.out_free;
      end
      ST_CNT: begin
        cmd_o.cnt_sat_load = sts_i.sat;
        cmd_o.cnt_load     = !sts_i.sat;
      end
      ST_HP: begin
        cmd_o.div_start = sts_i.need_hp;
      end
      ST_HP_WAIT: begin
        cmd_o.hp_load = sts_i.div_done;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
